@@ rtl/bwse_pkg.sv @@
// Shared types and constants of the beacon name extractor.
package bwse_pkg;

    // Parser phase within one captured frame.
    typedef enum logic [2:0] {
        PH_RADIO   = 3'd0,
        PH_CONTROL = 3'd1,
        PH_ADDRESS = 3'd2,
        PH_NAME    = 3'd3,
        PH_IGNORE  = 3'd4
    } phase_t;

    // Kind of a result word.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_NAME   = 2'd1,
        KIND_CUT    = 2'd2
    } kind_t;

    localparam int unsigned OFFSET_W = 17;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam logic [15:0] BEACON_CONTROL = 16'h8000;
    localparam logic [OFFSET_W-1:0] MGMT_BODY_OFFSET = 17'd24;
    localparam logic [OFFSET_W-1:0] SRC_ADDR_FIRST = 17'd10;
    localparam logic [OFFSET_W-1:0] SRC_ADDR_LAST = 17'd15;
    localparam logic [OFFSET_W-1:0] NAME_LEN_OFFSET = MGMT_BODY_OFFSET + 17'd13;
    localparam logic [15:0] MIN_RADIO_LEN = 16'd8;

    // Depth of the queue between parser and output stage.
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // One result word as it travels through the queue.
    typedef struct packed {
        kind_t       kind;
        logic [47:0] source_address;
        logic [5:0]  name_length;
        logic [7:0]  name_byte;
        logic        run_last;
    } bwse_result_t;

endpackage

@@ rtl/bwse_if.sv @@
// Handshake interfaces for the byte input, the result output and the channel register write.
interface bwse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface bwse_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  channel_out;
    logic [47:0] source_address;
    logic [5:0]  name_length;
    logic [7:0]  name_byte;
    logic        run_last;

    modport source (output valid, output result_kind, output channel_out,
                    output source_address, output name_length, output name_byte,
                    output run_last, input ready);
    modport sink (input valid, input result_kind, input channel_out,
                  input source_address, input name_length, input name_byte,
                  input run_last, output ready);
endinterface

interface bwse_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] channel_number;

    modport source (output valid, output channel_number, input ready);
    modport sink (input valid, input channel_number, output ready);
endinterface

@@ rtl/bwse_front.sv @@
// Byte parser: tracks the frame position and classifies bytes into result words.
module bwse_front #(
    parameter int unsigned MAX_NAME_LEN = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bwse_byte_if.sink             byte_in,
    input  logic                  q_full,
    output logic                  push,
    output bwse_pkg::bwse_result_t entry
);
    import bwse_pkg::*;

    localparam logic [7:0] NAME_MAX = 8'(MAX_NAME_LEN);

    phase_t                phase_reg, phase_next, phase_step;
    logic [OFFSET_W-1:0]   off_reg, off_next;
    logic [15:0]           rlen_reg, rlen_next;
    logic [47:0]           src_reg, src_next;
    logic [5:0]            left_reg, left_next;

    logic                  accept;
    logic [OFFSET_W-1:0]   rel;
    logic [15:0]           rlen_full;
    logic [5:0]            clip_len;
    logic [5:0]            left_dec;
    logic                  name_last;
    logic                  in_addr;

    assign byte_in.ready = !q_full;
    assign accept = byte_in.valid && !q_full;

    // Position relative to the start of the 802.11 header.
    assign rel = (off_reg >= {1'b0, rlen_reg}) ? (off_reg - {1'b0, rlen_reg}) : '0;
    assign rlen_full = {byte_in.data_byte, rlen_reg[7:0]};
    assign clip_len = (byte_in.data_byte > NAME_MAX) ? NAME_MAX[5:0] : byte_in.data_byte[5:0];
    assign left_dec = left_reg - 6'd1;
    assign name_last = (left_dec == 6'd0) || (byte_in.data_byte == 8'd0);
    assign in_addr = (rel >= SRC_ADDR_FIRST) && (rel <= SRC_ADDR_LAST);

    // Next state of the parser.
    always_comb
    begin
        phase_step = phase_reg;
        rlen_next  = rlen_reg;
        src_next   = src_reg;
        left_next  = left_reg;
        off_next   = off_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_RADIO:
                begin
                    if (off_reg == 17'd2)
                    begin
                        rlen_next = {8'd0, byte_in.data_byte};
                    end
                    else if (off_reg == 17'd3)
                    begin
                        rlen_next = rlen_full;
                        if (rlen_full < MIN_RADIO_LEN)
                        begin
                            phase_step = PH_IGNORE;
                        end
                    end
                    else if ((off_reg > 17'd3) &&
                             (({1'b0, off_reg} + 18'd1) == {2'b00, rlen_reg}))
                    begin
                        phase_step = PH_CONTROL;
                    end
                end
                PH_CONTROL:
                begin
                    if (rel == '0)
                    begin
                        if (byte_in.data_byte != BEACON_CONTROL[15:8])
                        begin
                            phase_step = PH_IGNORE;
                        end
                    end
                    else if (byte_in.data_byte != BEACON_CONTROL[7:0])
                    begin
                        phase_step = PH_IGNORE;
                    end
                    else
                    begin
                        phase_step = PH_ADDRESS;
                    end
                end
                PH_ADDRESS:
                begin
                    if (in_addr)
                    begin
                        src_next = {src_reg[39:0], byte_in.data_byte};
                    end
                    else if (rel == NAME_LEN_OFFSET)
                    begin
                        if (clip_len == 6'd0)
                        begin
                            phase_step = PH_IGNORE;
                        end
                        else
                        begin
                            left_next  = clip_len;
                            phase_step = PH_NAME;
                        end
                    end
                end
                PH_NAME:
                begin
                    left_next = left_dec;
                    if (name_last)
                    begin
                        phase_step = PH_IGNORE;
                    end
                end
                default:
                begin
                    phase_step = PH_IGNORE;
                end
            endcase
            phase_next = phase_step;
            if (off_reg != OFFSET_MAX)
            begin
                off_next = off_reg + 17'd1;
            end
            // The last byte of a frame rearms the parser.
            if (byte_in.frame_end)
            begin
                off_next   = '0;
                rlen_next  = '0;
                src_next   = '0;
                left_next  = '0;
                phase_next = PH_RADIO;
            end
        end
    end

    // Result word produced by the accepted byte.
    always_comb
    begin
        push  = 1'b0;
        entry = '{kind: KIND_HEADER, source_address: '0, name_length: '0,
                  name_byte: '0, run_last: 1'b0};
        if (accept)
        begin
            case (phase_reg)
                PH_ADDRESS:
                begin
                    if (!in_addr && (rel == NAME_LEN_OFFSET))
                    begin
                        push                 = 1'b1;
                        entry.kind           = KIND_HEADER;
                        entry.source_address = src_reg;
                        entry.name_length    = clip_len;
                        entry.run_last       = (clip_len == 6'd0);
                    end
                end
                PH_NAME:
                begin
                    push            = 1'b1;
                    entry.kind      = KIND_NAME;
                    entry.name_byte = byte_in.data_byte;
                    entry.run_last  = name_last;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
            // A frame that ends before its run is done reports a cut.
            if (byte_in.frame_end && (phase_step != PH_IGNORE))
            begin
                push  = 1'b1;
                entry = '{kind: KIND_CUT, source_address: '0, name_length: '0,
                          name_byte: '0, run_last: 1'b1};
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RADIO;
            off_reg   <= '0;
            rlen_reg  <= '0;
            src_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            rlen_reg  <= rlen_next;
            src_reg   <= src_next;
            left_reg  <= left_next;
        end
    end

    // A header word comes only from the address phase; on the last byte of a frame only
    // an empty name still gives a header word.
    a_header_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (entry.kind == KIND_HEADER)) |->
            (phase_reg == PH_ADDRESS) && (!byte_in.frame_end || entry.run_last))
        else $error("header word outside address phase");

    // A word is pushed only for an accepted byte.
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept)
        else $error("word pushed without an accepted byte");

    // The byte after a frame end starts again at offset zero in the radiotap phase.
    a_frame_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_in.frame_end) |=> (off_reg == '0) && (phase_reg == PH_RADIO))
        else $error("parser not rearmed after frame end");

endmodule

@@ rtl/bwse_queue.sv @@
// Short queue of result words between the parser and the output stage.
module bwse_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bwse_pkg::bwse_result_t push_data,
    input  logic                   pop,
    output logic                   full,
    output logic                   empty,
    output bwse_pkg::bwse_result_t head
);
    import bwse_pkg::*;

    bwse_result_t            mem [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]         count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue fill count out of range");

endmodule

@@ rtl/bwse_back.sv @@
// Output stage: holds the channel register and presents result words on the output channel.
module bwse_back (
    input  logic                   clk,
    input  logic                   rst_n,
    bwse_cfg_if.sink               cfg,
    bwse_result_if.source          result_out,
    input  logic                   q_empty,
    input  bwse_pkg::bwse_result_t q_head,
    output logic                   pop
);
    import bwse_pkg::*;

    logic [7:0]  channel_reg;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  chan_out_reg;
    logic [47:0] addr_reg;
    logic [5:0]  len_reg;
    logic [7:0]  nbyte_reg;
    logic        last_reg;

    assign cfg.ready = 1'b1;

    // Load a new word whenever the output register is empty or being taken.
    assign pop = !q_empty && (!valid_reg || result_out.ready);

    assign result_out.valid          = valid_reg;
    assign result_out.result_kind    = kind_reg;
    assign result_out.channel_out    = chan_out_reg;
    assign result_out.source_address = addr_reg;
    assign result_out.name_length    = len_reg;
    assign result_out.name_byte      = nbyte_reg;
    assign result_out.run_last       = last_reg;

    // Channel register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                channel_reg <= cfg.channel_number;
            end
            if (pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg     <= q_head.kind;
            chan_out_reg <= (q_head.kind == KIND_HEADER) ? channel_reg : 8'd0;
            addr_reg     <= q_head.source_address;
            len_reg      <= q_head.name_length;
            nbyte_reg    <= q_head.name_byte;
            last_reg     <= q_head.run_last;
        end
    end

endmodule

@@ rtl/wifi_beacon_ssid_extractor.sv @@
// Top level of the beacon name extractor.
//
// byte_in carries one captured frame byte per word (radiotap header, then
// the 802.11 frame), with frame_end set on the last byte. For every beacon
// the block sends a header word (channel, source address, name length) on
// result_out, then one word per name byte with run_last on the final one.
// A frame that ends before its run is done gives one cut-short word.
// cfg writes the channel number; it is always ready and should only be
// written while no frame is in flight.
//
// Throughput is one byte per cycle while the queue is not full: the parser
// decides each byte with one offset compare and register update. A result
// reaches result_out through a two-word queue that sits between the parser
// and the output register, so the parser keeps taking bytes while a result
// waits; byte_in.ready drops only once the queue is full behind a stalled
// receiver. Reset clears the parser to the start of a frame, empties the
// queue and sets the channel number to zero.
module wifi_beacon_ssid_extractor #(
    parameter int unsigned MAX_NAME_LEN = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    bwse_byte_if.sink     byte_in,
    bwse_result_if.source result_out,
    bwse_cfg_if.sink      cfg
);
    import bwse_pkg::*;

    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;
    bwse_result_t entry;
    bwse_result_t q_head;

    // Parser.
    bwse_front #(
        .MAX_NAME_LEN(MAX_NAME_LEN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .q_full  (q_full),
        .push    (push),
        .entry   (entry)
    );

    // Result queue.
    bwse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Output stage.
    bwse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .result_out (result_out),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .pop        (pop)
    );

endmodule
